// ----- rtl/frame_blit_with_edge_padding_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the frame blit block
// Clocked implication checks, disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef FRAME_BLIT_WITH_EDGE_PADDING_ASSERT_SVH
`define FRAME_BLIT_WITH_EDGE_PADDING_ASSERT_SVH

// same-cycle implication
`define FBP_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("fbp assertion failed");

// next-cycle implication
`define FBP_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("fbp assertion failed");

`endif

// ----- rtl/fbp_pkg.sv -----
// ----------------------------------------------------------------------------
// fbp_pkg
// Shared types and constants of the frame blit with edge padding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fbp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 15;
    localparam int PIX_W      = 32;
    localparam int IDX_W      = 28;
    localparam int POS_W      = 14;
    localparam int COORD_W    = 16;
    localparam int OUT_DATA_W = 64;

    localparam logic [CFG_DATA_W-1:0] EXTENT_MAX = 15'd16384;

    localparam logic [CFG_ADDR_W-1:0] REG_ATLAS_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PADDING      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_X       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_DEST_Y       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BASE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic base;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic done;
        logic out_free;
    } sts_t;

endpackage

// ----- rtl/fbp_ctrl.sv -----
// ----------------------------------------------------------------------------
// fbp_ctrl
// Sequencer: accept an item, form the row base, then emit its writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fbp_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  fbp_pkg::sts_t sts,
    output fbp_pkg::cmd_t cmd
);

    fbp_pkg::state_t state_reg;
    fbp_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fbp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            fbp_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = fbp_pkg::ST_BASE;
                end
            end
            fbp_pkg::ST_BASE: begin
                cmd.base   = 1'b1;
                state_next = fbp_pkg::ST_EMIT;
            end
            fbp_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    if (sts.done) begin
                        state_next = fbp_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = fbp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/fbp_datapath.sv -----
// ----------------------------------------------------------------------------
// fbp_datapath
// Config registers, frame position, write span and output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "frame_blit_with_edge_padding_assert.svh"

module fbp_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fbp_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [fbp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic [fbp_pkg::PIX_W-1:0]         s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbp_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                              m_tlast,
    input  fbp_pkg::cmd_t                     cmd,
    output fbp_pkg::sts_t                     sts
);

    logic [14:0] aw_reg;
    logic [1:0]  pad_reg;
    logic [13:0] dx_reg;
    logic [13:0] dy_reg;
    logic [14:0] fw_reg;
    logic [14:0] fh_reg;
    logic [13:0] col_pos_reg;
    logic [13:0] row_pos_reg;

    logic [31:0] value_reg;
    logic [15:0] col_reg;
    logic [15:0] row_reg;
    logic [15:0] x0_reg;
    logic [15:0] x1_reg;
    logic [15:0] y1_reg;
    logic [27:0] base_reg;

    logic        m_tvalid_reg;
    logic [27:0] out_index_reg;
    logic [31:0] out_value_reg;
    logic        out_last_reg;

    logic        cfg_hit;
    logic [14:0] fw_eff;
    logic [14:0] fh_eff;
    logic [14:0] w_last;
    logic [14:0] h_last;
    logic [13:0] c_eff;
    logic [13:0] r_eff;
    logic        c_first;
    logic        c_last;
    logic        r_first;
    logic        r_last;
    logic [15:0] x_mid;
    logic [15:0] y_mid;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] y0;
    logic [15:0] y1;
    logic [30:0] prod;
    logic        at_col_end;
    logic [27:0] out_index;

    always_comb begin
        unique case (cfg_index)
            fbp_pkg::REG_ATLAS_WIDTH, fbp_pkg::REG_PADDING, fbp_pkg::REG_DEST_X,
            fbp_pkg::REG_DEST_Y, fbp_pkg::REG_FRAME_WIDTH,
            fbp_pkg::REG_FRAME_HEIGHT: cfg_hit = cfg_wr_en;
            default:                   cfg_hit = 1'b0;
        endcase
    end

    // clamp frame extent to one through the maximum
    assign fw_eff = (fw_reg == 15'd0) ? 15'd1 :
                    (fw_reg > fbp_pkg::EXTENT_MAX) ? fbp_pkg::EXTENT_MAX : fw_reg;
    assign fh_eff = (fh_reg == 15'd0) ? 15'd1 :
                    (fh_reg > fbp_pkg::EXTENT_MAX) ? fbp_pkg::EXTENT_MAX : fh_reg;
    assign w_last = fw_eff - 15'd1;
    assign h_last = fh_eff - 15'd1;

    assign c_eff   = ({1'b0, col_pos_reg} > w_last) ? w_last[13:0] : col_pos_reg;
    assign r_eff   = ({1'b0, row_pos_reg} > h_last) ? h_last[13:0] : row_pos_reg;
    assign c_first = (c_eff == 14'd0);
    assign r_first = (r_eff == 14'd0);
    assign c_last  = (c_eff == w_last[13:0]);
    assign r_last  = (r_eff == h_last[13:0]);

    assign x_mid = {2'b00, dx_reg} + {14'd0, pad_reg} + {2'b00, c_eff};
    assign y_mid = {2'b00, dy_reg} + {14'd0, pad_reg} + {2'b00, r_eff};
    assign x0    = c_first ? {2'b00, dx_reg} : x_mid;
    assign y0    = r_first ? {2'b00, dy_reg} : y_mid;
    assign x1    = c_last ? (x_mid + {14'd0, pad_reg}) : x_mid;
    assign y1    = r_last ? (y_mid + {14'd0, pad_reg}) : y_mid;

    assign prod       = {15'd0, row_reg} * {16'd0, aw_reg};
    assign at_col_end = (col_reg == x1_reg);
    assign out_index  = base_reg + {12'd0, col_reg};

    assign sts.done     = at_col_end && (row_reg == y1_reg);
    assign sts.out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            aw_reg      <= 15'd64;
            pad_reg     <= 2'd0;
            dx_reg      <= 14'd0;
            dy_reg      <= 14'd0;
            fw_reg      <= 15'd1;
            fh_reg      <= 15'd1;
            col_pos_reg <= 14'd0;
            row_pos_reg <= 14'd0;
        end else if (cfg_hit) begin
            case (cfg_index)
                fbp_pkg::REG_ATLAS_WIDTH:  aw_reg <= cfg_wdata;
                fbp_pkg::REG_PADDING:      pad_reg <= cfg_wdata[1:0];
                fbp_pkg::REG_DEST_X:       dx_reg <= cfg_wdata[13:0];
                fbp_pkg::REG_DEST_Y:       dy_reg <= cfg_wdata[13:0];
                fbp_pkg::REG_FRAME_WIDTH:  fw_reg <= cfg_wdata;
                fbp_pkg::REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                default: ;
            endcase
            col_pos_reg <= 14'd0;
            row_pos_reg <= 14'd0;
        end else if (cmd.load) begin
            if (c_last) begin
                col_pos_reg <= 14'd0;
                row_pos_reg <= r_last ? 14'd0 : r_eff + 14'd1;
            end else begin
                col_pos_reg <= c_eff + 14'd1;
                row_pos_reg <= r_eff;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= s_tdata;
            col_reg   <= x0;
            row_reg   <= y0;
            x0_reg    <= x0;
            x1_reg    <= x1;
            y1_reg    <= y1;
        end else if (cmd.base) begin
            base_reg <= prod[27:0];
        end else if (cmd.emit) begin
            if (at_col_end) begin
                col_reg  <= x0_reg;
                row_reg  <= row_reg + 16'd1;
                base_reg <= base_reg + {13'd0, aw_reg};
            end else begin
                col_reg <= col_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_index_reg <= out_index;
            out_value_reg <= value_reg;
            out_last_reg  <= sts.done;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    `FBP_ASSERT_IMP(a_emit_slot_free, aclk, aresetn, cmd.emit, !m_tvalid_reg || m_tready)
    `FBP_ASSERT_IMP(a_emit_in_span, aclk, aresetn, cmd.emit, (col_reg <= x1_reg) && (row_reg <= y1_reg))
    `FBP_ASSERT_NXT(a_span_ordered, aclk, aresetn, cmd.load, (x1_reg >= x0_reg) && (y1_reg >= row_reg))

endmodule

// ----- rtl/frame_blit_with_edge_padding.sv -----
// Flow: once an item is accepted, one step forms the row base with a multiplier,
// then the item's writes (one for an interior pixel) leave one write per cycle,
// while m_tready does not stall the output, through the single output register;
// the next item is accepted only after the last write of the current one is issued.
// Reset: registers return to defaults (atlas width 64, frame 1x1), frame position
// to zero; no clearing pass, the block accepts items right after reset.
// ----------------------------------------------------------------------------
// frame_blit_with_edge_padding
// Places frame pixels in an atlas and replicates border pixels by the padding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frame_blit_with_edge_padding (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [fbp_pkg::CFG_ADDR_W-1:0]    cfg_index,
    input  logic [fbp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [fbp_pkg::PIX_W-1:0]         s_tdata,   // [31:0] pixel_value
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [fbp_pkg::OUT_DATA_W-1:0]    m_tdata,   // [27:0] pixel_index, [59:28] write_value
    output logic                              m_tlast    // last_write
);

    fbp_pkg::cmd_t cmd;
    fbp_pkg::sts_t sts;

    fbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fbp_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
